>>> src/xopd_pkg.sv
// Shared types and constants for the x86 operand pattern decoder.
// No dependencies; used by xopd_decode and x86_operand_pattern_decoder.
`timescale 1ns / 1ps

package xopd_pkg;

  typedef enum logic [2:0] {
    FORM_NONE    = 3'd0,
    FORM_REG_IND = 3'd1,
    FORM_JMP_SIB = 3'd2,
    FORM_MOVSXD  = 3'd3,
    FORM_LEA_RIP = 3'd4,
    FORM_MOV_SIB = 3'd5
  } form_e;

  typedef struct packed {
    logic [63:0] window_low;
    logic [63:0] window_high;
    logic [4:0]  bytes_valid;
    logic [63:0] insn_address;
  } in_item_t;

  typedef struct packed {
    form_e              form_kind;
    logic [3:0]         dest_reg;
    logic [3:0]         sib_base;
    logic [3:0]         index_reg;
    logic [3:0]         scale_factor;
    logic signed [31:0] displacement;
    logic [4:0]         insn_length;
    logic [63:0]        rip_target;
  } out_item_t;

  localparam logic [7:0] OPC_GRP5   = 8'hff;
  localparam logic [7:0] OPC_MOVSXD = 8'h63;
  localparam logic [7:0] OPC_LEA    = 8'h8d;
  localparam logic [7:0] OPC_MOV    = 8'h8b;
  localparam logic [3:0] REX_HIGH   = 4'h4;

  localparam logic [1:0] MOD_NONE   = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;
  localparam logic [2:0] REG_CALL   = 3'd2;
  localparam logic [2:0] REG_JMP    = 3'd4;
  localparam logic [2:0] RM_SIB     = 3'd4;
  localparam logic [2:0] RM_RIP     = 3'd5;
  localparam logic [2:0] IDX_NONE   = 3'd4;
  localparam logic [2:0] BASE_NONE  = 3'd5;
  localparam logic [1:0] SCALE_X4   = 2'd2;

  function automatic logic is_legacy(logic [7:0] b);
    return b == 8'h3e || b == 8'h66 || b == 8'h67 || b == 8'hf2 || b == 8'hf3 ||
           b == 8'hf0 || b == 8'h2e || b == 8'h36 || b == 8'h26 || b == 8'h64 ||
           b == 8'h65;
  endfunction

endpackage

>>> src/xopd_decode.sv
// Combinational decode of one instruction window: prefix scan, form match,
// operand fields and rip-relative target. Depends on xopd_pkg.
`timescale 1ns / 1ps

module xopd_decode import xopd_pkg::*; #(
  parameter int WindowBytes = 16
) (
  input  in_item_t  item_i,
  output out_item_t result_o
);

  localparam logic [4:0] WinLen = 5'(WindowBytes);

  logic [127:0] wide_w;
  logic [7:0]   win_w [WindowBytes];
  logic [4:0]   size_w;
  logic [4:0]   op_w;
  logic [2:0]   rex_w;
  logic [7:0]   b_w [7];
  logic [4:0]   pos_w [7];

  logic         rr, rx, rbx;
  logic [7:0]   opc, modrm, sib;
  logic [1:0]   md, sc;
  logic [2:0]   reg_f, rm, si, sb;
  logic         sib_ok, idx_bad;
  logic [31:0]  d32;
  logic [4:0]   len_w;

  assign wide_w = {item_i.window_high, item_i.window_low};
  assign size_w = (item_i.bytes_valid > WinLen) ? WinLen : item_i.bytes_valid;

  always_comb begin
    for (int i = 0; i < WindowBytes; i++) begin
      win_w[i] = wide_w[8*i +: 8];
    end
  end

  // first byte that is neither a legacy prefix nor REX
  always_comb begin
    op_w = size_w;
    for (int i = WindowBytes - 1; i >= 0; i--) begin
      if (5'(i) < size_w && !is_legacy(win_w[i]) && win_w[i][7:4] != REX_HIGH) begin
        op_w = 5'(i);
      end
    end
  end

  // last REX byte ahead of the opcode wins
  always_comb begin
    rex_w = 3'd0;
    for (int i = 0; i < WindowBytes; i++) begin
      if (5'(i) < op_w && win_w[i][7:4] == REX_HIGH) begin
        rex_w = win_w[i][2:0];
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 7; k++) begin
      pos_w[k] = op_w + 5'(k);
      b_w[k]   = 8'd0;
      for (int i = 0; i < WindowBytes; i++) begin
        if (pos_w[k] == 5'(i)) begin
          b_w[k] = win_w[i];
        end
      end
    end
  end

  always_comb begin
    rr      = rex_w[2];
    rx      = rex_w[1];
    rbx     = rex_w[0];
    opc     = b_w[0];
    modrm   = b_w[1];
    sib_ok  = pos_w[2] < size_w;
    sib     = sib_ok ? b_w[2] : 8'd0;
    md      = modrm[7:6];
    reg_f   = modrm[5:3];
    rm      = modrm[2:0];
    sc      = sib[7:6];
    si      = sib[5:3];
    sb      = sib[2:0];
    idx_bad = (si == IDX_NONE) && !rx;
    d32     = {b_w[5], b_w[4], b_w[3], b_w[2]};
    len_w   = 5'd0;

    result_o              = '0;
    result_o.form_kind    = FORM_NONE;
    result_o.scale_factor = 4'd1;

    if (pos_w[1] < size_w) begin
      if (opc == OPC_GRP5 && md == MOD_REG && (reg_f == REG_CALL || reg_f == REG_JMP)) begin
        result_o.form_kind = FORM_REG_IND;
        result_o.dest_reg  = {rbx, rm};
      end else if (opc == OPC_GRP5 && sib_ok && md == MOD_NONE && reg_f == REG_JMP &&
                   rm == RM_SIB && !idx_bad && sb != BASE_NONE) begin
        result_o.form_kind    = FORM_JMP_SIB;
        result_o.sib_base     = {rbx, sb};
        result_o.index_reg    = {rx, si};
        result_o.scale_factor = 4'd1 << sc;
        result_o.insn_length  = op_w + 5'd3;
      end else if (opc == OPC_MOVSXD && sib_ok && md != MOD_REG && rm == RM_SIB &&
                   !idx_bad && !(md == MOD_NONE && sb == BASE_NONE) && sc == SCALE_X4) begin
        result_o.form_kind    = FORM_MOVSXD;
        result_o.dest_reg     = {rr, reg_f};
        result_o.sib_base     = {rbx, sb};
        result_o.index_reg    = {rx, si};
        result_o.scale_factor = 4'd4;
        case (md)
          MOD_DISP8:  result_o.insn_length = op_w + 5'd4;
          MOD_DISP32: result_o.insn_length = op_w + 5'd7;
          default:    result_o.insn_length = op_w + 5'd3;
        endcase
      end else if (opc == OPC_LEA && pos_w[5] < size_w && md == MOD_NONE && rm == RM_RIP) begin
        len_w                = op_w + 5'd6;
        result_o.form_kind   = FORM_LEA_RIP;
        result_o.dest_reg    = {rr, reg_f};
        result_o.insn_length = len_w;
        result_o.rip_target  = item_i.insn_address + 64'(len_w) + {{32{d32[31]}}, d32};
      end else if (opc == OPC_MOV && sib_ok && md != MOD_REG && rm == RM_SIB &&
                   !idx_bad && !(md == MOD_NONE && sb == BASE_NONE)) begin
        if (md == MOD_NONE || (md == MOD_DISP8 && pos_w[3] < size_w) ||
            (md == MOD_DISP32 && pos_w[6] < size_w)) begin
          result_o.form_kind    = FORM_MOV_SIB;
          result_o.dest_reg     = {rr, reg_f};
          result_o.sib_base     = {rbx, sb};
          result_o.index_reg    = {rx, si};
          result_o.scale_factor = 4'd1 << sc;
          case (md)
            MOD_DISP8: begin
              result_o.displacement = $signed({{24{b_w[3][7]}}, b_w[3]});
              result_o.insn_length  = op_w + 5'd4;
            end
            MOD_DISP32: begin
              result_o.displacement = $signed({b_w[6], b_w[5], b_w[4], b_w[3]});
              result_o.insn_length  = op_w + 5'd7;
            end
            default: begin
              result_o.insn_length = op_w + 5'd3;
            end
          endcase
        end
      end
    end
  end

endmodule

>>> src/x86_operand_pattern_decoder.sv
// Throughput: one item per cycle while out_stall_i does not hold the output.
// Path: input register, decode logic, result register.
// Reset: asynchronous active-low rst_ni clears both valid flags; no other state.
// Top level of the x86 operand pattern decoder.
// Depends on xopd_pkg and xopd_decode.
`timescale 1ns / 1ps

module x86_operand_pattern_decoder import xopd_pkg::*; #(
  parameter int WINDOW_BYTES = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  logic      s1_valid_q, s1_valid_d;
  in_item_t  s1_item_q;
  logic      out_valid_q, out_valid_d;
  out_item_t out_item_q;
  out_item_t result_w;
  logic      s2_ready, s1_ready;

  assign s2_ready    = !out_valid_q || !out_stall_i;
  assign s1_ready    = !s1_valid_q || s2_ready;
  assign in_stall_o  = !s1_ready;
  assign s1_valid_d  = s1_ready ? in_valid_i : s1_valid_q;
  assign out_valid_d = s2_ready ? s1_valid_q : out_valid_q;

  xopd_decode #(
    .WindowBytes(WINDOW_BYTES)
  ) u_decode (
    .item_i  (s1_item_q),
    .result_o(result_w)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_item_q <= in_item_i;
    end
    if (s2_ready && s1_valid_q) begin
      out_item_q <= result_w;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

`ifndef ASSERT_OFF
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && out_valid_q && out_stall_i)
    else $error("input stalled with free stage");

  a_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s2_ready |=> out_valid_o)
    else $error("decoded item lost");

  a_none_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.form_kind == FORM_NONE |->
      out_item_o.insn_length == 5'd0 && out_item_o.rip_target == 64'd0 &&
      out_item_o.scale_factor == 4'd1)
    else $error("no-match result carries operands");

  a_lea_no_sib: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.form_kind == FORM_LEA_RIP |->
      out_item_o.sib_base == 4'd0 && out_item_o.index_reg == 4'd0 &&
      out_item_o.displacement == 32'sd0)
    else $error("rip-relative result carries SIB fields");
`endif

endmodule
